FILE: rtl/core/fdpt_pkg.sv
`timescale 1ns / 1ps
// fdpt_pkg: payload types and fixed field widths for the fifo demand paging table
// no dependencies; imported by the core and used as the stream interface payload

package fdpt_pkg;

    localparam int ADDR_W     = 16;
    localparam int PAGE_OUT_W = 5;
    localparam int LABEL_W    = 9;
    localparam int TIME_W     = 32;

    // frame label is LABEL_BANK * (f / LABEL_ROW + 1) + f % LABEL_ROW + 1
    localparam int LABEL_BANK = 100;
    localparam int LABEL_ROW  = 5;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } access_t;

    typedef struct packed {
        logic [PAGE_OUT_W-1:0] page_index;
        logic [LABEL_W-1:0]    frame_label;
        logic                  hit;
        logic                  evict_valid;
        logic [PAGE_OUT_W-1:0] evicted_page;
        logic                  evicted_dirty;
        logic [TIME_W-1:0]     access_time;
        logic                  out_of_range;
    } result_t;

endpackage

FILE: rtl/core/fdpt_stream_if.sv
`timescale 1ns / 1ps
// fdpt_stream_if: valid/ready channel carrying one payload item per transfer
// payload type is a parameter, normally a struct from fdpt_pkg

interface fdpt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/fifo_demand_paging_table_core.sv
`timescale 1ns / 1ps
// FIFO demand paging table. Each access transfer carries an address and a write flag;
// the page number is address / PAGE_SIZE, formed by a reciprocal multiply on the way
// into the input register. The second stage looks the page up in the flop-based page
// and frame tables, picks the round-robin victim frame on a miss, updates the tables
// and the saturating access counter in the same cycle, and loads the result register.
// One access is taken every cycle; a result passes the input register and then the
// result register, and both stages stall only when the result register is full and
// not taken. The tables are read and written back in the same cycle, which sets the
// rate. No clearing pass after reset. Depends on fdpt_pkg and fdpt_stream_if.

module fifo_demand_paging_table_core #(
    parameter int NUM_FRAMES = 15,
    parameter int NUM_PAGES  = 26,
    parameter int PAGE_SIZE  = 200
) (
    input  logic          clk,
    input  logic          rst_n,
    fdpt_stream_if.sink   access,
    fdpt_stream_if.source result
);
    import fdpt_pkg::*;

    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    // exact quotient for every 16-bit address: m = ceil(2^(16+l) / d), l = ceil(log2 d)
    localparam int              DIV_L     = $clog2(PAGE_SIZE);
    localparam int              DIV_SHIFT = ADDR_W + DIV_L;
    localparam int              MUL_W     = ADDR_W + 1;
    localparam int              PROD_W    = ADDR_W + MUL_W;
    localparam longint unsigned DIV_MUL_FULL =
        ((64'd1 << DIV_SHIFT) + PAGE_SIZE - 1) / PAGE_SIZE;
    localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_FULL);

    // input stage
    logic [PROD_W-1:0] div_prod;
    logic [ADDR_W-1:0] page_full;
    logic              page_oor;
    logic              s1_valid_reg;
    logic              s1_oor_reg;
    logic [PW-1:0]     s1_page_reg;
    logic              s1_write_reg;
    logic              s1_adv;

    // tables
    logic [NUM_PAGES-1:0]  page_mapped_reg;
    logic [NUM_PAGES-1:0]  page_dirty_reg;
    logic [FW-1:0]         page_frame_reg [NUM_PAGES];
    logic [NUM_FRAMES-1:0] frame_in_use_reg;
    logic [PW-1:0]         frame_owner_reg [NUM_FRAMES];
    logic [FW-1:0]         next_victim_reg;
    logic [FW-1:0]         next_victim_next;
    logic [TIME_W-1:0]     count_reg;
    logic [TIME_W-1:0]     count_inc;
    logic [LABEL_W-1:0]    label_tbl [NUM_FRAMES];

    // lookup
    logic          hit;
    logic [FW-1:0] victim;
    logic [PW-1:0] old_page;
    logic          evict;
    logic          evict_dirty;
    logic [FW-1:0] frame;
    logic          do_update;

    // result stage
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t out_data_next;

    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_label
        assign label_tbl[g] =
            LABEL_W'(LABEL_BANK * (g / LABEL_ROW + 1) + g % LABEL_ROW + 1);
    end

    // ---------------- input stage ----------------
    assign div_prod  = PROD_W'(access.data.address) * PROD_W'(DIV_MUL);
    assign page_full = ADDR_W'(div_prod >> DIV_SHIFT);
    assign page_oor  = (page_full >= ADDR_W'(NUM_PAGES));

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign access.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (access.ready)
        begin
            s1_valid_reg <= access.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (access.valid && access.ready)
        begin
            s1_oor_reg   <= page_oor;
            s1_page_reg  <= page_oor ? '0 : PW'(page_full);
            s1_write_reg <= access.data.is_write;
        end
    end

    // ---------------- lookup and update ----------------
    assign hit         = page_mapped_reg[s1_page_reg];
    assign victim      = next_victim_reg;
    assign old_page    = frame_owner_reg[victim];
    assign evict       = !hit && frame_in_use_reg[victim];
    assign evict_dirty = evict && page_dirty_reg[old_page];
    assign frame       = hit ? page_frame_reg[s1_page_reg] : victim;
    assign do_update   = s1_adv && !s1_oor_reg;

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign next_victim_next = (victim == FW'(NUM_FRAMES - 1)) ? '0 : victim + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_mapped_reg  <= '0;
            page_dirty_reg   <= '0;
            frame_in_use_reg <= '0;
            next_victim_reg  <= '0;
            count_reg        <= '0;
        end
        else if (do_update)
        begin
            count_reg <= count_inc;
            if (hit)
            begin
                if (s1_write_reg)
                begin
                    page_dirty_reg[s1_page_reg] <= 1'b1;
                end
            end
            else
            begin
                // old owner cannot be the requested page, it is unmapped
                if (evict)
                begin
                    page_mapped_reg[old_page] <= 1'b0;
                end
                page_mapped_reg[s1_page_reg] <= 1'b1;
                page_dirty_reg[s1_page_reg]  <= s1_write_reg;
                frame_in_use_reg[victim]     <= 1'b1;
                next_victim_reg              <= next_victim_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_update && !hit)
        begin
            frame_owner_reg[victim]     <= s1_page_reg;
            page_frame_reg[s1_page_reg] <= victim;
        end
    end

    // ---------------- result stage ----------------
    always_comb
    begin
        out_data_next = '0;
        if (s1_oor_reg)
        begin
            out_data_next.access_time  = count_reg;
            out_data_next.out_of_range = 1'b1;
        end
        else
        begin
            out_data_next.page_index    = PAGE_OUT_W'(s1_page_reg);
            out_data_next.frame_label   = label_tbl[frame];
            out_data_next.hit           = hit;
            out_data_next.evict_valid   = evict;
            out_data_next.evicted_page  = evict ? PAGE_OUT_W'(old_page) : '0;
            out_data_next.evicted_dirty = evict_dirty;
            out_data_next.access_time   = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ---------------- assertions ----------------
    // the number of mapped pages equals the number of frames in use
    a_map_balance: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(page_mapped_reg) == $countones(frame_in_use_reg))
        else $error("mapped page count differs from frames in use");

    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_victim_reg < FW'(NUM_FRAMES - 1) || next_victim_reg == FW'(NUM_FRAMES - 1))
        else $error("victim pointer beyond frame count");

    a_page_mapped: assert property (@(posedge clk) disable iff (!rst_n)
        do_update |=> page_mapped_reg[$past(s1_page_reg)])
        else $error("accessed page not mapped after update");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> count_reg >= $past(count_reg))
        else $error("access counter went backwards");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.evict_valid) |-> !result.data.hit)
        else $error("eviction reported on a hit");

endmodule

FILE: tb/fdpt_checker.sv
`timescale 1ns / 1ps
// fdpt_checker: watches the access and result channels of the paging table core,
// predicts each result from its own page and frame tables and compares field by field
// depends on fdpt_pkg; instantiated next to the core by tb_fifo_demand_paging_table_core

module fdpt_checker #(
    parameter int NUM_FRAMES = 15,
    parameter int NUM_PAGES  = 26,
    parameter int PAGE_SIZE  = 200
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              access_valid,
    input  logic              access_ready,
    input  fdpt_pkg::access_t access_data,
    input  logic              result_valid,
    input  logic              result_ready,
    input  fdpt_pkg::result_t result_data,
    output int                mismatches,
    output int                pending
);
    import fdpt_pkg::*;

    // mirror of the page table, frame table and fifo pointer
    int unsigned       frame_of_page [NUM_PAGES];
    bit                page_resident [NUM_PAGES];
    bit                page_modified [NUM_PAGES];
    logic [TIME_W-1:0] page_stamp    [NUM_PAGES];
    int unsigned       frame_page    [NUM_FRAMES];
    bit                frame_busy    [NUM_FRAMES];
    int unsigned       fifo_ptr;
    logic [TIME_W-1:0] access_total;

    result_t expected_results [$];
    result_t want;

    function automatic result_t translate_access(access_t acc);
        result_t     r;
        int unsigned page;
        int unsigned frame;
        int unsigned old;
        r = '0;
        page = acc.address / PAGE_SIZE;
        if (page >= NUM_PAGES)
        begin
            r.access_time  = access_total;
            r.out_of_range = 1'b1;
            return r;
        end
        if (access_total != '1)
            access_total++;
        if (page_resident[page])
        begin
            r.hit = 1'b1;
            frame = frame_of_page[page];
            if (frame >= NUM_FRAMES)
                frame = 0;
            if (acc.is_write)
                page_modified[page] = 1'b1;
        end
        else
        begin
            if (fifo_ptr >= NUM_FRAMES)
                fifo_ptr = 0;
            frame = fifo_ptr;
            // the frame's previous owner loses its mapping
            if (frame_busy[frame])
            begin
                old = frame_page[frame];
                if (old < NUM_PAGES)
                begin
                    r.evict_valid   = 1'b1;
                    r.evicted_page  = PAGE_OUT_W'(old);
                    r.evicted_dirty = page_modified[old];
                    page_resident[old] = 1'b0;
                end
            end
            frame_page[frame]   = page;
            frame_busy[frame]   = 1'b1;
            page_resident[page] = 1'b1;
            frame_of_page[page] = frame;
            page_modified[page] = acc.is_write;
            fifo_ptr = frame + 1;
            if (fifo_ptr >= NUM_FRAMES)
                fifo_ptr = 0;
        end
        page_stamp[page] = access_total;
        r.page_index  = PAGE_OUT_W'(page);
        r.frame_label = LABEL_W'(LABEL_BANK * (frame / LABEL_ROW + 1) + frame % LABEL_ROW + 1);
        r.access_time = access_total;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned exp_val,
                                        longint unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                frame_of_page[i] = 0;
                page_resident[i] = 1'b0;
                page_modified[i] = 1'b0;
                page_stamp[i]    = '0;
            end
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                frame_page[i] = 0;
                frame_busy[i] = 1'b0;
            end
            fifo_ptr     = 0;
            access_total = '0;
            mismatches   = 0;
            expected_results.delete();
        end
        else
        begin
            if (access_valid && access_ready)
                expected_results.insert(expected_results.size(),
                                        translate_access(access_data));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no access outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("page_index", want.page_index, result_data.page_index);
                    check_field("frame_label", want.frame_label, result_data.frame_label);
                    check_field("hit", want.hit, result_data.hit);
                    check_field("evict_valid", want.evict_valid, result_data.evict_valid);
                    check_field("evicted_page", want.evicted_page, result_data.evicted_page);
                    check_field("evicted_dirty", want.evicted_dirty,
                                result_data.evicted_dirty);
                    check_field("access_time", want.access_time, result_data.access_time);
                    check_field("out_of_range", want.out_of_range,
                                result_data.out_of_range);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: tb/tb_fifo_demand_paging_table_core.sv
`timescale 1ns / 1ps
// tb_fifo_demand_paging_table_core: drives memory accesses into the paging table core
// with random stalls on both channels; fdpt_checker predicts and compares the results
// depends on fdpt_pkg, fdpt_stream_if, fifo_demand_paging_table_core and fdpt_checker

module tb_fifo_demand_paging_table_core;
    import fdpt_pkg::*;

    localparam int NUM_FRAMES  = 15;
    localparam int NUM_PAGES   = 26;
    localparam int PAGE_SIZE   = 200;
    localparam int TABLE_END   = NUM_PAGES * PAGE_SIZE;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 255;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    bit   idling = 1'b0;
    int   burst_left = 0;
    int   stall_cycles = 0;
    int   mismatches;
    int   pending;

    fdpt_stream_if #(.T(access_t)) access_ch ();
    fdpt_stream_if #(.T(result_t)) result_ch ();

    fifo_demand_paging_table_core #(
        .NUM_FRAMES(NUM_FRAMES),
        .NUM_PAGES (NUM_PAGES),
        .PAGE_SIZE (PAGE_SIZE)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .access(access_ch),
        .result(result_ch)
    );

    fdpt_checker #(
        .NUM_FRAMES(NUM_FRAMES),
        .NUM_PAGES (NUM_PAGES),
        .PAGE_SIZE (PAGE_SIZE)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .access_valid(access_ch.valid),
        .access_ready(access_ch.ready),
        .access_data (access_ch.data),
        .result_valid(result_ch.valid),
        .result_ready(result_ch.ready),
        .result_data (result_ch.data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // holds valid until the transfer, leaves at the next falling edge
    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic wr);
        int gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            access_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        access_ch.valid <= 1'b1;
        access_ch.data  <= '{address: addr, is_write: wr};
        do
            @(posedge clk);
        while (access_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // result side back-pressure
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst_left > 0)
            begin
                result_ch.ready <= 1'b0;
                burst_left--;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                burst_left = $urandom_range(0, 12);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (access_ch.valid && access_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int                lo;
        int                hi;
        int                roll;
        int                page;
        logic [ADDR_W-1:0] addr;

        access_ch.valid = 1'b0;
        access_ch.data  = '0;
        rst_n           = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // page 0 first and last byte, page 1, page 25 at the table end, then past it
        send_access('0, 1'b0);
        send_access(ADDR_W'(PAGE_SIZE - 1), 1'b1);
        send_access(ADDR_W'(PAGE_SIZE), 1'b0);
        send_access(ADDR_W'(TABLE_END - 1), 1'b1);
        send_access(ADDR_W'(TABLE_END), 1'b0);
        send_access(16'hFFFF, 1'b1);
        // fill the remaining frames
        for (int p = 2; p <= 13; p++)
            send_access(ADDR_W'(p * PAGE_SIZE + p), p[0]);
        // full table: dirty page 0 then clean page 1 lose their frames
        send_access(ADDR_W'(14 * PAGE_SIZE), 1'b0);
        send_access(ADDR_W'(15 * PAGE_SIZE + 100), 1'b1);
        send_access(ADDR_W'(TABLE_END - 50), 1'b0);
        send_access('0, 1'b1);
        send_access(ADDR_W'(PAGE_SIZE - 1), 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // only even phases before the last run with stalls
            idling = (phase < PHASES - 1) && (phase % 2 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // working set of 4 to 14 pages moves around, always fits the frames
                if (n % 40 == 0)
                begin
                    lo = $urandom_range(0, 12);
                    hi = lo + $urandom_range(3, 13);
                end
                roll = $urandom_range(0, 99);
                if (roll < 9)
                begin
                    addr = ADDR_W'($urandom_range(TABLE_END, 65535));
                end
                else if (roll == 9)
                begin
                    case ($urandom_range(0, 3))
                        0:       addr = ADDR_W'(TABLE_END - 1);
                        1:       addr = ADDR_W'(TABLE_END);
                        2:       addr = '0;
                        default: addr = 16'hFFFF;
                    endcase
                end
                else
                begin
                    page = $urandom_range(lo, hi);
                    addr = ADDR_W'(page * PAGE_SIZE + $urandom_range(0, PAGE_SIZE - 1));
                end
                send_access(addr, 1'($urandom_range(0, 1)));
            end
        end
        access_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/fdpt_pkg.sv
rtl/core/fdpt_stream_if.sv
rtl/core/fifo_demand_paging_table_core.sv
tb/fdpt_checker.sv
tb/tb_fifo_demand_paging_table_core.sv
